FILE: hw/rtl/svnl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svnl_pkg
// Shared constants, types and helpers of the surface voxel neighbor linker.
// ----------------------------------------------------------------------------
package svnl_pkg;

	// volume limits per axis
	localparam int MAX_VOXELS_X = 64;
	localparam int MAX_VOXELS_Y = 64;
	localparam int MAX_VOXELS_Z = 64;

	// coordinate widths inside the block
	localparam int X_W = $clog2(MAX_VOXELS_X);
	localparam int Y_W = $clog2(MAX_VOXELS_Y);
	localparam int Z_W = $clog2(MAX_VOXELS_Z);

	// fixed field widths at the ports
	localparam int DIM_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CUBE_W    = 8;
	localparam int POS_W     = 6;
	localparam int IDX_W     = 18;
	localparam int CNT_W     = 19;
	localparam int ENTRY_W   = IDX_W + 1;

	// width that holds every axis length and every register value
	localparam int MAX_XY  = (MAX_VOXELS_X > MAX_VOXELS_Y) ? MAX_VOXELS_X : MAX_VOXELS_Y;
	localparam int MAX_XYZ = (MAX_XY > MAX_VOXELS_Z) ? MAX_XY : MAX_VOXELS_Z;
	localparam int MAX_ALL = (MAX_XYZ > (2 ** DIM_W) - 1) ? MAX_XYZ : (2 ** DIM_W) - 1;
	localparam int LEN_W   = $clog2(MAX_ALL + 2);

	// slice store geometry
	localparam int SLICE_DEPTH = MAX_VOXELS_X * MAX_VOXELS_Y;
	localparam int SLICE_AW    = $clog2(SLICE_DEPTH);

	// cube configurations that make no surface
	localparam logic [CUBE_W-1:0] CUBE_EMPTY = 8'h00;
	localparam logic [CUBE_W-1:0] CUBE_FULL  = 8'hff;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VOXELS_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOXELS_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VOXELS_Z = 2'd2;

	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

	// per-voxel information carried to the neighbor lookup stage
	typedef struct packed {
		logic               surf;
		logic [IDX_W-1:0]   node_idx;
		logic [X_W-1:0]     x;
		logic [Y_W-1:0]     y;
		logic [Z_W-1:0]     z;
		logic               use_bottom;
		logic               use_front;
		logic [ENTRY_W-1:0] right_entry;
		logic               vend;
	} voxel_info_t;

	// register value to usable axis length: zero acts as one, clamp to limit
	function automatic logic [LEN_W-1:0] effective_len(input logic [DIM_W-1:0] r,
			input logic [LEN_W-1:0] maxv);
		logic [LEN_W-1:0] rv;
		rv = LEN_W'(r);
		if (rv == '0) begin
			return LEN_W'(1);
		end else if (rv > maxv) begin
			return maxv;
		end
		return rv;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/surface_voxel_neighbor_linker_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// surface_voxel_neighbor_linker_unit
// Streams cube configurations in raster order, numbers the surface voxels and
// links each to its bottom, front and right neighbor nodes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/cube_config): one cube configuration
//   per voxel, x fastest, then y, then z. The block counts the position.
//   Output channel (out_valid/out_ready/...): one result per voxel, in order.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//   index 0..2 sets voxels_x/y/z, other indexes are ignored. Write only idle.
// Timing:
//   A result is presented from the output register: the stores are read at the
//   accept edge, and the output register loads when the lookup stage advances.
//   One voxel per cycle sustained while out_ready is high: the slice and row
//   stores are each read and written once per voxel on accept; no forwarding.
// Reset:
//   Position, node count and right neighbor clear, the axis registers go to
//   64. The stores need no clearing; edge voxels never consult them.
// Stall:
//   A held result sits in the output register while one more request is taken
//   into the lookup stage; beyond that in_ready drops.
// ----------------------------------------------------------------------------
module surface_voxel_neighbor_linker_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	// config write
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [svnl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [svnl_pkg::DIM_W-1:0]        cfg_data,
	// voxel input
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire  [svnl_pkg::CUBE_W-1:0]       cube_config,
	// result output
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic                              is_surface,
	output logic [svnl_pkg::IDX_W-1:0]        node_index,
	output logic [svnl_pkg::POS_W-1:0]        voxel_x,
	output logic [svnl_pkg::POS_W-1:0]        voxel_y,
	output logic [svnl_pkg::POS_W-1:0]        voxel_z,
	output logic                              has_bottom,
	output logic [svnl_pkg::IDX_W-1:0]        bottom_index,
	output logic                              has_front,
	output logic [svnl_pkg::IDX_W-1:0]        front_index,
	output logic                              has_right,
	output logic [svnl_pkg::IDX_W-1:0]        right_index,
	output logic                              volume_end
);

	localparam int LEN_W   = svnl_pkg::LEN_W;
	localparam int ENTRY_W = svnl_pkg::ENTRY_W;
	localparam int IDX_W   = svnl_pkg::IDX_W;

	// axis registers
	logic [svnl_pkg::DIM_W-1:0] voxels_x_q, voxels_y_q, voxels_z_q;

	// scan state
	logic [svnl_pkg::X_W-1:0] scan_x_q;
	logic [svnl_pkg::Y_W-1:0] scan_y_q;
	logic [svnl_pkg::Z_W-1:0] scan_z_q;
	logic [svnl_pkg::CNT_W-1:0] node_count_q;
	logic [ENTRY_W-1:0] prev_voxel_q;

	// pipeline
	logic                  s1_valid_q;
	svnl_pkg::voxel_info_t info_s1;
	svnl_pkg::voxel_info_t info_d;
	logic                  out_valid_q;
	logic                  accept, s1_adv;

	logic [ENTRY_W-1:0] slice_rd, row_rd;

	logic [LEN_W-1:0] vx, vy, vz;
	logic             surf, end_x, end_y, end_z, vend;
	logic [ENTRY_W-1:0] entry;
	logic [svnl_pkg::SLICE_AW-1:0] slice_addr;

	logic [ENTRY_W-1:0] bottom_e, front_e;

	assign cfg_ready = 1'b1;

	// handshake
	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;
	assign accept   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// classify the voxel and find where the scan goes next
	always_comb begin
		vx = svnl_pkg::effective_len(voxels_x_q, LEN_W'(svnl_pkg::MAX_VOXELS_X));
		vy = svnl_pkg::effective_len(voxels_y_q, LEN_W'(svnl_pkg::MAX_VOXELS_Y));
		vz = svnl_pkg::effective_len(voxels_z_q, LEN_W'(svnl_pkg::MAX_VOXELS_Z));
		surf  = (cube_config != svnl_pkg::CUBE_EMPTY) && (cube_config != svnl_pkg::CUBE_FULL);
		end_x = (LEN_W'(scan_x_q) + LEN_W'(1)) >= vx;
		end_y = (LEN_W'(scan_y_q) + LEN_W'(1)) >= vy;
		end_z = (LEN_W'(scan_z_q) + LEN_W'(1)) >= vz;
		vend  = end_x && end_y && end_z;
		entry = surf ? {1'b1, node_count_q[IDX_W-1:0]} : '0;
		slice_addr = svnl_pkg::SLICE_AW'(scan_y_q) * svnl_pkg::SLICE_AW'(svnl_pkg::MAX_VOXELS_X)
			+ svnl_pkg::SLICE_AW'(scan_x_q);

		info_d.surf        = surf;
		info_d.node_idx    = entry[IDX_W-1:0];
		info_d.x           = scan_x_q;
		info_d.y           = scan_y_q;
		info_d.z           = scan_z_q;
		info_d.use_bottom  = surf && (scan_z_q != '0);
		info_d.use_front   = surf && (scan_y_q != '0);
		info_d.right_entry = (surf && (scan_x_q != '0)) ? prev_voxel_q : '0;
		info_d.vend        = vend;
	end

	// slice store: one entry per x,y of the previous slice
	svnl_ram #(
		.DEPTH (svnl_pkg::SLICE_DEPTH),
		.WIDTH (ENTRY_W)
	) u_slice_ram (
		.clk   (clk),
		.en    (accept),
		.addr  (slice_addr),
		.wdata (entry),
		.rdata (slice_rd)
	);

	// row store: one entry per x of the previous row
	svnl_ram #(
		.DEPTH (svnl_pkg::MAX_VOXELS_X),
		.WIDTH (ENTRY_W)
	) u_row_ram (
		.clk   (clk),
		.en    (accept),
		.addr  (scan_x_q),
		.wdata (entry),
		.rdata (row_rd)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voxels_x_q <= svnl_pkg::DIM_RESET;
			voxels_y_q <= svnl_pkg::DIM_RESET;
			voxels_z_q <= svnl_pkg::DIM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				svnl_pkg::REG_VOXELS_X: voxels_x_q <= cfg_data;
				svnl_pkg::REG_VOXELS_Y: voxels_y_q <= cfg_data;
				svnl_pkg::REG_VOXELS_Z: voxels_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// scan position, node count and right neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_x_q     <= '0;
			scan_y_q     <= '0;
			scan_z_q     <= '0;
			node_count_q <= '0;
			prev_voxel_q <= '0;
		end else if (accept) begin
			prev_voxel_q <= entry;
			if (surf) begin
				node_count_q <= node_count_q + svnl_pkg::CNT_W'(1);
			end
			if (vend) begin
				scan_x_q     <= '0;
				scan_y_q     <= '0;
				scan_z_q     <= '0;
				node_count_q <= '0;
				prev_voxel_q <= '0;
			end else if (!end_x) begin
				scan_x_q <= scan_x_q + svnl_pkg::X_W'(1);
			end else begin
				scan_x_q     <= '0;
				prev_voxel_q <= '0;
				if (!end_y) begin
					scan_y_q <= scan_y_q + svnl_pkg::Y_W'(1);
				end else begin
					scan_y_q <= '0;
					scan_z_q <= scan_z_q + svnl_pkg::Z_W'(1);
				end
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// lookup stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info_d;
		end
	end

	// gate the store reads by the volume edges
	assign bottom_e = info_s1.use_bottom ? slice_rd : '0;
	assign front_e  = info_s1.use_front ? row_rd : '0;

	// output register
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			is_surface   <= info_s1.surf;
			node_index   <= info_s1.node_idx;
			voxel_x      <= svnl_pkg::POS_W'(info_s1.x);
			voxel_y      <= svnl_pkg::POS_W'(info_s1.y);
			voxel_z      <= svnl_pkg::POS_W'(info_s1.z);
			has_bottom   <= bottom_e[ENTRY_W-1];
			bottom_index <= bottom_e[ENTRY_W-1] ? bottom_e[IDX_W-1:0] : '0;
			has_front    <= front_e[ENTRY_W-1];
			front_index  <= front_e[ENTRY_W-1] ? front_e[IDX_W-1:0] : '0;
			has_right    <= info_s1.right_entry[ENTRY_W-1];
			right_index  <= info_s1.right_entry[ENTRY_W-1] ?
				info_s1.right_entry[IDX_W-1:0] : '0;
			volume_end   <= info_s1.vend;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/svnl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svnl_ram
// Single-port synchronous RAM, registered read of the old contents.
// ----------------------------------------------------------------------------
module svnl_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 19
) (
	input  wire                       clk,
	input  wire                       en,
	input  wire  [$clog2(DEPTH)-1:0]  addr,
	input  wire  [WIDTH-1:0]          wdata,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read then write the same address in one access
	always_ff @(posedge clk) begin
		if (en) begin
			rdata     <= mem[addr];
			mem[addr] <= wdata;
		end
	end

endmodule
`default_nettype wire
